FILE: sv/vkfrs_pkg.sv
// Shared types and constants for the value-keyed find-and-replace store.
// No dependencies; the interfaces, the controller and the top level import this package.
package vkfrs_pkg;

  localparam int DEPTH    = 64;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;
  localparam int CNTOUT_W = 7;
  localparam int KIND_W   = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_LOAD    = 2'd1,
    KIND_REPLACE = 2'd2,
    KIND_READ    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } ram_cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         found_position;
    status_t                  status;
    logic [CNTOUT_W-1:0]      count;
  } result_t;

endpackage

FILE: sv/vkfrs_req_if.sv
// Request channel: valid/ready handshake with one operation per beat.
// Depends on vkfrs_pkg for field widths.
interface vkfrs_req_if import vkfrs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;
  logic signed [DATA_W-1:0] new_value;
  logic [POS_W-1:0]         position;

  modport source (output valid, kind, value, new_value, position, input ready);
  modport sink   (input valid, kind, value, new_value, position, output ready);
endinterface

FILE: sv/vkfrs_rsp_if.sv
// Response channel: valid/ready handshake with one result per beat.
// Depends on vkfrs_pkg for field widths.
interface vkfrs_rsp_if import vkfrs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [POS_W-1:0]         found_position;
  logic [1:0]               status;
  logic [CNTOUT_W-1:0]      count;

  modport source (output valid, read_value, found_position, status, count, input ready);
  modport sink   (input valid, read_value, found_position, status, count, output ready);
endinterface

FILE: sv/vkfrs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies.
module vkfrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/vkfrs_ctrl.sv
// Operation sequencer: element count, memory access and the replace scan.
// Depends on vkfrs_pkg and vkfrs_req_if; drives the store RAM via ram_cmd_t.
module vkfrs_ctrl import vkfrs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  vkfrs_req_if.sink         req,
  output ram_cmd_t          ram_cmd,
  input  logic [DATA_W-1:0] ram_rdata,
  output logic              res_valid,
  output result_t           res,
  input  logic              res_take
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_RDWAIT = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [DATA_W-1:0] key;
  logic [DATA_W-1:0] repl;
  logic [CNT_W-1:0]  scan_idx;
  logic              cmp_valid;
  logic [IDX_W-1:0]  cmp_idx;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic [DATA_W-1:0] res_read;
  logic [IDX_W-1:0]  res_fpos;
  status_t           res_status;

  logic  accept;
  kind_t kind;
  logic  pos_ok;
  logic  full;
  logic  scan_issue;
  logic  scan_done;

  assign req.ready  = (state == S_IDLE) && !rst;
  assign accept     = req.valid && req.ready;
  assign kind       = kind_t'(req.kind);
  assign pos_ok     = (32'(req.position) < 32'(count));
  assign full       = (count == CNT_W'(DEPTH));
  assign scan_issue = (state == S_SCAN) && (scan_idx < count);
  // last compare has retired once nothing is issued and nothing is in flight
  assign scan_done  = (state == S_SCAN) && !scan_issue && !cmp_valid;

  // Reads and writes of one entry never share a cycle: each operation finishes
  // its accesses before the next is accepted.
  always_comb begin
    ram_cmd       = '0;
    ram_cmd.wdata = repl;
    if (accept && kind == KIND_LOAD && !full) begin
      ram_cmd.we    = 1'b1;
      ram_cmd.waddr = count[IDX_W-1:0];
      ram_cmd.wdata = req.value;
    end
    if (accept && kind == KIND_READ && pos_ok) begin
      ram_cmd.re    = 1'b1;
      ram_cmd.raddr = IDX_W'(req.position);
    end
    if (scan_issue) begin
      ram_cmd.re    = 1'b1;
      ram_cmd.raddr = scan_idx[IDX_W-1:0];
    end
    if (scan_done && hit) begin
      ram_cmd.we    = 1'b1;
      ram_cmd.waddr = hit_idx;
      ram_cmd.wdata = repl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= scan_issue;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (kind)
              KIND_CLEAR: begin
                count <= '0;
                state <= S_FINISH;
              end
              KIND_LOAD: begin
                if (!full) begin
                  count <= count + 1'b1;
                end
                state <= S_FINISH;
              end
              KIND_REPLACE: begin
                state <= (count == '0) ? S_FINISH : S_SCAN;
              end
              KIND_READ: begin
                state <= pos_ok ? S_RDWAIT : S_FINISH;
              end
              default: state <= S_FINISH;
            endcase
          end
        end
        S_RDWAIT: state <= S_FINISH;
        S_SCAN: begin
          if (scan_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key        <= req.value;
      repl       <= req.new_value;
      scan_idx   <= '0;
      hit        <= 1'b0;
      res_read   <= '0;
      res_fpos   <= (kind == KIND_LOAD && !full) ? count[IDX_W-1:0] : '0;
      res_status <= (kind == KIND_LOAD && full)              ? ST_FULL :
                    (kind == KIND_REPLACE && count == '0)    ? ST_NOT_FOUND :
                    (kind == KIND_READ && !pos_ok)           ? ST_RANGE :
                                                               ST_OK;
    end
    if (scan_issue) begin
      scan_idx <= scan_idx + 1'b1;
    end
    cmp_idx <= scan_idx[IDX_W-1:0];
    // later positions overwrite earlier ones, so the highest match wins
    if (state == S_SCAN && cmp_valid && ram_rdata == key) begin
      hit     <= 1'b1;
      hit_idx <= cmp_idx;
    end
    if (scan_done) begin
      if (hit) begin
        res_fpos <= hit_idx;
      end else begin
        res_status <= ST_NOT_FOUND;
      end
    end
    if (state == S_RDWAIT) begin
      res_read <= ram_rdata;
    end
  end

  assign res_valid          = (state == S_FINISH);
  assign res.read_value     = res_read;
  assign res.found_position = POS_W'(res_fpos);
  assign res.status         = res_status;
  assign res.count          = CNTOUT_W'(count);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("element count beyond store depth");

  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    !(ram_cmd.we && ram_cmd.re && ram_cmd.waddr == ram_cmd.raddr))
    else $error("read and write of one entry in the same cycle");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("beat accepted while an operation is in flight");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.kind == KIND_CLEAR) |=> (count == '0))
    else $error("clear did not empty the store");

  a_scan_ends_cleanly: assert property (@(posedge clk) disable iff (rst)
    scan_done |-> !scan_issue && !ram_cmd.re)
    else $error("replace finished with a read outstanding");

endmodule

FILE: sv/value_keyed_find_and_replace_store_unit.sv
// Top level of the value-keyed find-and-replace store.
// Depends on vkfrs_pkg, vkfrs_req_if, vkfrs_rsp_if, vkfrs_ram and vkfrs_ctrl.

// Holds up to DEPTH signed 32-bit values in a single-port-read RAM and takes
// one operation per request beat. Clear and load go from accept straight to
// the result state; read passes through a RAM wait state first; replace scans
// the occupied positions through the RAM read port, one entry a cycle, and
// that scan sets the rate. A new request is taken once the previous result has
// moved into the output register, so a result waiting on a stalled consumer
// does not hold off the next operation. The store needs no clearing pass after
// reset: entries at or above the element count are never read.
module value_keyed_find_and_replace_store_unit import vkfrs_pkg::*; (
  input logic         clk,
  input logic         rst,
  vkfrs_req_if.sink   req,
  vkfrs_rsp_if.source rsp
);

  ram_cmd_t          ram_cmd;
  logic [DATA_W-1:0] ram_rdata;
  logic              res_valid;
  result_t           res;
  logic              res_take;
  logic              out_valid;
  result_t           out_res;

  vkfrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ram_cmd   (ram_cmd),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  vkfrs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_cmd.we),
    .waddr (ram_cmd.waddr),
    .wdata (ram_cmd.wdata),
    .re    (ram_cmd.re),
    .raddr (ram_cmd.raddr),
    .rdata (ram_rdata)
  );

  // load the output register when it is empty or its beat leaves this cycle
  assign res_take = res_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.read_value     = out_res.read_value;
  assign rsp.found_position = out_res.found_position;
  assign rsp.status         = out_res.status;
  assign rsp.count          = out_res.count;

endmodule
